>>> design/rbte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbte_pkg
// Shared constants, codes and types for the record blob text extractor.
// ----------------------------------------------------------------------------
package rbte_pkg;

  localparam int MAX_TABLE_DIM_DEF = 1024;
  localparam int MAX_VERSION       = 5;

  // Up to three words per input byte: cell byte, cell space, final status
  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  // Record type bytes
  localparam logic [7:0] RTYPE_END   = 8'h00;
  localparam logic [7:0] RTYPE_TEXT  = 8'h01;
  localparam logic [7:0] RTYPE_IMAGE = 8'h02;
  localparam logic [7:0] RTYPE_TABLE = 8'h03;
  localparam logic [7:0] RTYPE_CHECK = 8'h04;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Final status codes
  localparam logic [2:0] ST_END_MARKER = 3'd0;
  localparam logic [2:0] ST_NO_MARKER  = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_BAD_VER    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;
  localparam logic [2:0] ST_BAD_TABLE  = 3'd5;
  localparam logic [2:0] ST_UNKNOWN    = 3'd6;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        is_final;
    logic [2:0]  status;
    logic [31:0] drop_count;
    logic        last_of_run;
  } res_t;

  // Current magic, byte by byte
  function automatic logic [7:0] magic_cur(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h42; // B
      2'd1:    c = 8'h4E; // N
      2'd2:    c = 8'h42; // B
      default: c = 8'h46; // F
    endcase
    return c;
  endfunction

  // Legacy magic, byte by byte
  function automatic logic [7:0] magic_leg(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h4F; // O
      2'd1:    c = 8'h4E; // N
      2'd2:    c = 8'h42; // B
      default: c = 8'h46; // F
    endcase
    return c;
  endfunction

endpackage

>>> design/record_blob_text_extract_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_blob_text_extract_unit
// Streams a record-structured blob byte by byte and emits its plain text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one blob byte per word, with
//   blob_last on the final byte. Output channel (out_valid / out_stall) carries
//   one result word each: a text byte, the space after a table cell, or the
//   end-of-blob status word (is_final set, with status and drop_count).
//   last_of_run marks the final word caused by one input byte.
//   Latency: a byte's first word is offered the cycle after acceptance if the queue was empty.
//   Throughput: one byte per cycle while the receiver does not stall and each byte yields at most one word.
//   The last data byte of a cell yields two words and a last byte up to three;
//   they leave a 4-entry result queue one per cycle, and the input stalls
//   whenever more than one word is queued (so three new words always fit).
//   When the receiver stalls, the queue holds its head word steady and fills
//   up to that limit before the input stalls.
//   Reset (rst, synchronous) empties the queue and returns the parser to
//   waiting for the first magic byte; it also does so after each final word.
// ----------------------------------------------------------------------------
module record_blob_text_extract_unit #(
  parameter int MAX_TABLE_DIM = rbte_pkg::MAX_TABLE_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  blob_byte,
  input  logic        blob_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  text_byte,
  output logic        is_final,
  output logic [2:0]  status,
  output logic [31:0] drop_count,
  output logic        last_of_run
);
  import rbte_pkg::*;

  localparam int DIM_W   = $clog2(MAX_TABLE_DIM + 1);
  localparam int CELLS_W = 2 * DIM_W;

  // Parser phases
  localparam logic [3:0] PH_MAGIC      = 4'd0;
  localparam logic [3:0] PH_VERSION    = 4'd1;
  localparam logic [3:0] PH_RECTYPE    = 4'd2;
  localparam logic [3:0] PH_TEXT_FLAGS = 4'd3;
  localparam logic [3:0] PH_TEXT_LEN   = 4'd4;
  localparam logic [3:0] PH_TEXT_DATA  = 4'd5;
  localparam logic [3:0] PH_IMG_WIDTH  = 4'd6;
  localparam logic [3:0] PH_IMG_LEN    = 4'd7;
  localparam logic [3:0] PH_IMG_DATA   = 4'd8;
  localparam logic [3:0] PH_TAB_FLAGS  = 4'd9;
  localparam logic [3:0] PH_TAB_ROWS   = 4'd10;
  localparam logic [3:0] PH_TAB_COLS   = 4'd11;
  localparam logic [3:0] PH_CELL_LEN   = 4'd12;
  localparam logic [3:0] PH_CELL_DATA  = 4'd13;
  localparam logic [3:0] PH_CHECK      = 4'd14;
  localparam logic [3:0] PH_STOPPED    = 4'd15;

  // Parser state
  logic [3:0]         phase, phase_next;
  logic [1:0]         magic_live, magic_live_next; // bit0 current, bit1 legacy
  logic [31:0]        acc, acc_next;               // little-endian field
  logic [1:0]         idx, idx_next;               // byte within field
  logic [2:0]         version, version_next;
  logic [DIM_W-1:0]   rows, rows_next;             // 0 marks out of range
  logic [CELLS_W-1:0] cells, cells_next;
  logic [31:0]        pl, pl_next;                 // payload bytes left
  logic [31:0]        pe, pe_next;                 // payload bytes emitted
  logic [2:0]         stop, stop_next;

  // Result queue
  res_t               fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  logic               accept, pop;
  logic [31:0]        field_full;
  logic               field_done;
  logic [1:0]         mk;
  logic               emit_data, emit_space, emit_final;
  logic [2:0]         fin_status;
  logic [31:0]        fin_drop;
  logic [1:0]         n_new;
  res_t               r_data, r_space, r_final;
  res_t               slot [MAX_RESULTS];
  logic [DIM_W-1:0]   cols_val;
  logic [CELLS_W-1:0] cells_dec;

  function automatic logic dim_ok(input logic [31:0] v);
    return (v >= 32'd1) && (v <= 32'(MAX_TABLE_DIM));
  endfunction

  assign in_stall = (count > CNT_W'(FIFO_DEPTH - MAX_RESULTS));
  assign accept   = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign pop      = out_valid && !out_stall;

  assign field_full = acc | ({24'd0, blob_byte} << {idx, 3'b000});
  assign field_done = (idx == 2'd3);
  assign cols_val   = field_full[DIM_W-1:0];
  assign cells_dec  = cells - CELLS_W'(1);
  assign mk = {(blob_byte == magic_leg(idx)), (blob_byte == magic_cur(idx))};

  always_comb begin
    phase_next      = phase;
    magic_live_next = magic_live;
    acc_next        = acc;
    idx_next        = idx;
    version_next    = version;
    rows_next       = rows;
    cells_next      = cells;
    pl_next         = pl;
    pe_next         = pe;
    stop_next       = stop;
    emit_data       = 1'b0;
    emit_space      = 1'b0;
    emit_final      = 1'b0;
    fin_status      = ST_END_MARKER;
    fin_drop        = '0;

    if (accept) begin
      // Field phases: gather bytes, or clear the gatherer when complete
      if (phase != PH_MAGIC && !field_done) begin
        acc_next = field_full;
        idx_next = idx + 2'd1;
      end else if (phase != PH_MAGIC) begin
        acc_next = '0;
        idx_next = '0;
      end

      case (phase)
        PH_MAGIC: begin
          magic_live_next = magic_live & mk;
          if ((magic_live & mk) == 2'b00) begin
            phase_next = PH_STOPPED;
            stop_next  = ST_BAD_HEADER;
          end else if (field_done) begin
            phase_next = PH_VERSION;
            acc_next   = '0;
            idx_next   = '0;
          end else begin
            idx_next = idx + 2'd1;
          end
        end
        PH_VERSION: begin
          if (field_done) begin
            if (field_full < 32'd1 || field_full > 32'(MAX_VERSION)) begin
              phase_next = PH_STOPPED;
              stop_next  = ST_BAD_VER;
            end else begin
              version_next = field_full[2:0];
              phase_next   = PH_RECTYPE;
            end
          end
        end
        PH_RECTYPE: begin
          acc_next = '0;
          idx_next = '0;
          case (blob_byte)
            RTYPE_END: begin
              phase_next = PH_STOPPED;
              stop_next  = ST_END_MARKER;
            end
            RTYPE_TEXT:  phase_next = PH_TEXT_FLAGS;
            RTYPE_IMAGE: phase_next = (version >= 3'd2) ? PH_IMG_WIDTH : PH_IMG_LEN;
            RTYPE_TABLE: phase_next = (version >= 3'd4) ? PH_TAB_FLAGS : PH_TAB_ROWS;
            RTYPE_CHECK: phase_next = PH_CHECK;
            default: begin
              phase_next = PH_STOPPED;
              stop_next  = ST_UNKNOWN;
            end
          endcase
        end
        PH_TEXT_FLAGS: begin
          if (field_done) phase_next = PH_TEXT_LEN;
        end
        PH_TEXT_LEN: begin
          if (field_done) begin
            pl_next    = field_full;
            pe_next    = '0;
            phase_next = (field_full == '0) ? PH_RECTYPE : PH_TEXT_DATA;
          end
        end
        PH_TEXT_DATA: begin
          emit_data = 1'b1;
          pe_next   = pe + 32'd1;
          pl_next   = pl - 32'd1;
          acc_next  = '0;
          idx_next  = '0;
          if (pl == 32'd1) begin
            pe_next    = '0;
            phase_next = PH_RECTYPE;
          end
        end
        PH_IMG_WIDTH: begin
          if (field_done) phase_next = PH_IMG_LEN;
        end
        PH_IMG_LEN: begin
          if (field_done) begin
            pl_next    = field_full;
            phase_next = (field_full == '0) ? PH_RECTYPE : PH_IMG_DATA;
          end
        end
        PH_IMG_DATA: begin
          pl_next  = pl - 32'd1;
          acc_next = '0;
          idx_next = '0;
          if (pl == 32'd1) phase_next = PH_RECTYPE;
        end
        PH_TAB_FLAGS: begin
          if (field_done) phase_next = PH_TAB_ROWS;
        end
        PH_TAB_ROWS: begin
          if (field_done) begin
            rows_next  = dim_ok(field_full) ? field_full[DIM_W-1:0] : '0;
            phase_next = PH_TAB_COLS;
          end
        end
        PH_TAB_COLS: begin
          if (field_done) begin
            if (rows == '0 || !dim_ok(field_full)) begin
              phase_next = PH_STOPPED;
              stop_next  = ST_BAD_TABLE;
            end else begin
              cells_next = CELLS_W'(rows) * CELLS_W'(cols_val);
              phase_next = PH_CELL_LEN;
            end
          end
        end
        PH_CELL_LEN: begin
          if (field_done) begin
            pl_next = field_full;
            pe_next = '0;
            if (field_full == '0) begin
              // empty cell: space only, then the cell is done
              emit_space = 1'b1;
              cells_next = cells_dec;
              phase_next = (cells_dec == '0) ? PH_RECTYPE : PH_CELL_LEN;
            end else begin
              phase_next = PH_CELL_DATA;
            end
          end
        end
        PH_CELL_DATA: begin
          emit_data = 1'b1;
          pe_next   = pe + 32'd1;
          pl_next   = pl - 32'd1;
          acc_next  = '0;
          idx_next  = '0;
          if (pl == 32'd1) begin
            emit_space = 1'b1;
            pe_next    = '0;
            cells_next = cells_dec;
            phase_next = (cells_dec == '0) ? PH_RECTYPE : PH_CELL_LEN;
          end
        end
        PH_CHECK: begin
          acc_next   = '0;
          idx_next   = '0;
          phase_next = PH_RECTYPE;
        end
        default: begin
          // stopped: ignore bytes until the last one
          acc_next = acc;
          idx_next = idx;
        end
      endcase

      if (blob_last) begin
        emit_final = 1'b1;
        if (phase_next == PH_STOPPED) begin
          fin_status = stop_next;
        end else if (phase_next == PH_MAGIC || phase_next == PH_VERSION) begin
          fin_status = ST_BAD_HEADER;
        end else if (phase_next == PH_RECTYPE) begin
          fin_status = ST_NO_MARKER;
        end else begin
          fin_status = ST_TRUNCATED;
          fin_drop   = pe_next;
        end
        // back to reset state for the next blob
        phase_next      = PH_MAGIC;
        magic_live_next = 2'b11;
        acc_next        = '0;
        idx_next        = '0;
        version_next    = '0;
        rows_next       = '0;
        cells_next      = '0;
        pl_next         = '0;
        pe_next         = '0;
        stop_next       = ST_END_MARKER;
      end
    end
  end

  // Words for this byte, in order: data byte, cell space, final status
  always_comb begin
    n_new = 2'(emit_data) + 2'(emit_space) + 2'(emit_final);

    r_data  = '{text_byte: blob_byte, is_final: 1'b0, status: ST_END_MARKER,
                drop_count: '0, last_of_run: 1'b0};
    r_space = '{text_byte: CHAR_SPACE, is_final: 1'b0, status: ST_END_MARKER,
                drop_count: '0, last_of_run: 1'b0};
    r_final = '{text_byte: 8'd0, is_final: 1'b1, status: fin_status,
                drop_count: fin_drop, last_of_run: 1'b0};

    slot[0] = emit_data ? r_data : (emit_space ? r_space : r_final);
    slot[1] = (emit_data && emit_space) ? r_space : r_final;
    slot[2] = r_final;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      slot[k].last_of_run = (k == int'(n_new) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MAGIC;
      magic_live <= 2'b11;
      acc        <= '0;
      idx        <= '0;
      version    <= '0;
      rows       <= '0;
      cells      <= '0;
      pl         <= '0;
      pe         <= '0;
      stop       <= ST_END_MARKER;
    end else begin
      phase      <= phase_next;
      magic_live <= magic_live_next;
      acc        <= acc_next;
      idx        <= idx_next;
      version    <= version_next;
      rows       <= rows_next;
      cells      <= cells_next;
      pl         <= pl_next;
      pe         <= pe_next;
      stop       <= stop_next;
    end
  end

  // Result queue payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (k < int'(n_new)) fifo[wr_ptr + PTR_W'(k)] <= slot[k];
    end
  end

  // Result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_new);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count  <= count + CNT_W'(n_new) - CNT_W'(pop);
    end
  end

  assign text_byte   = fifo[rd_ptr].text_byte;
  assign is_final    = fifo[rd_ptr].is_final;
  assign status      = fifo[rd_ptr].status;
  assign drop_count  = fifo[rd_ptr].drop_count;
  assign last_of_run = fifo[rd_ptr].last_of_run;

endmodule

>>> test/record_blob_text_extract_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_blob_text_extract_unit_tb
// Self-checking bench for the blob text extractor: blobs fed byte by byte,
// every result word compared against a behavioural parser kept in step.
// ----------------------------------------------------------------------------
module record_blob_text_extract_unit_tb;
  import rbte_pkg::*;

  // --------------------------------------------------------------------------
  // Bench constants
  // --------------------------------------------------------------------------
  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 10;
  localparam int IDLE_PCT     = 6;       // chance of an idle cycle on each side
  localparam int HOLD_CYCLES  = 80;      // long receiver hold-off
  localparam int ITEM_TARGET  = 250;     // random bytes sent after the table
  localparam int DRAIN_CYCLES = 20;      // settle time once nothing is pending
  localparam int CYCLE_LIMIT  = 200000;  // watchdog
  localparam int MAX_DIM      = MAX_TABLE_DIM_DEF;

  // Version thresholds for the optional record fields
  localparam int VER_IMG_WIDTH = 2;
  localparam int VER_TBL_FLAGS = 4;

  // Current and legacy magic, index 0 is the first byte on the wire
  localparam logic [3:0][7:0] MAGIC_NEW = {8'h46, 8'h42, 8'h4E, 8'h42};
  localparam logic [3:0][7:0] MAGIC_OLD = {8'h46, 8'h42, 8'h4E, 8'h4F};

  // Parser position within the blob
  typedef enum logic [4:0] {
    S_MAGIC, S_VERSION, S_REC_TYPE, S_TXT_FLAGS, S_TXT_LEN, S_TXT_BODY,
    S_IMG_WIDTH, S_IMG_LEN, S_IMG_BODY, S_TBL_FLAGS, S_TBL_ROWS, S_TBL_COLS,
    S_CELL_LEN, S_CELL_BODY, S_CHECKBOX, S_HALTED
  } parse_pos_e;

  // One row of the directed table; status is typed in only where obvious
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic [2:0] st;
  } dir_row_t;

  localparam int DIR_N = 20;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  blob_byte = 8'h00;
  logic        blob_last = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  text_byte;
  logic        is_final;
  logic [2:0]  status;
  logic [31:0] drop_count;
  logic        last_of_run;

  always #(CLK_PERIOD / 2) clk = ~clk;

  record_blob_text_extract_unit #(
    .MAX_TABLE_DIM(MAX_DIM)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .blob_byte  (blob_byte),
    .blob_last  (blob_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .text_byte  (text_byte),
    .is_final   (is_final),
    .status     (status),
    .drop_count (drop_count),
    .last_of_run(last_of_run)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  res_t        pending_words[$];   // expected result words, oldest first
  logic [7:0]  blob_bytes[$];      // blob under construction
  int unsigned error_count  = 0;
  int unsigned sent_bytes   = 0;   // bytes accepted since the last clear
  int unsigned cycle_count  = 0;
  logic        calm         = 1'b0; // no idling on either side while set
  logic        hold_req     = 1'b0; // asks the receiver for a long hold-off
  dir_row_t    directed [DIR_N];

  // --------------------------------------------------------------------------
  // Parser model: own copy of the extractor state
  // --------------------------------------------------------------------------
  parse_pos_e  pos;
  logic [1:0]  magic_live;   // bit 0 current magic, bit 1 legacy magic
  logic [31:0] field_acc;
  logic [1:0]  field_idx;
  logic [2:0]  fmt_ver;
  logic [10:0] tbl_rows;
  logic [10:0] tbl_cols;
  logic [20:0] cells_todo;
  logic [31:0] body_left;
  logic [31:0] body_sent;    // bytes of the open text record or cell so far
  logic [2:0]  halt_code;
  int          words_now;    // words caused by the byte being modelled

  task clear_parser();
    pos        = S_MAGIC;
    magic_live = 2'b11;
    field_acc  = '0;
    field_idx  = '0;
    fmt_ver    = '0;
    tbl_rows   = '0;
    tbl_cols   = '0;
    cells_todo = '0;
    body_left  = '0;
    body_sent  = '0;
    halt_code  = ST_END_MARKER;
  endtask

  task go_to(input parse_pos_e p);
    pos       = p;
    field_acc = '0;
    field_idx = '0;
  endtask

  task halt_with(input logic [2:0] code);
    pos       = S_HALTED;
    halt_code = code;
  endtask

  // Little-endian u32 gather; true once the fourth byte is in
  function bit absorb(input logic [7:0] b);
    field_acc = field_acc | ({24'd0, b} << (8 * field_idx));
    if (field_idx == 2'd3) begin
      field_idx = '0;
      return 1'b1;
    end
    field_idx = field_idx + 2'd1;
    return 1'b0;
  endfunction

  task emit(input logic [7:0] ch, input logic fin, input logic [2:0] st,
            input logic [31:0] drop);
    res_t r;
    r.text_byte   = ch;
    r.is_final    = fin;
    r.status      = st;
    r.drop_count  = drop;
    r.last_of_run = 1'b0;
    pending_words.push_back(r);
    words_now++;
  endtask

  task close_cell();
    body_sent = '0;
    if (cells_todo != 0) cells_todo = cells_todo - 1'b1;
    if (cells_todo == 0) go_to(S_REC_TYPE);
    else go_to(S_CELL_LEN);
  endtask

  // Advances the model by one accepted byte and queues the words it causes
  task extract_step(input logic [7:0] b, input logic last);
    res_t        r;
    logic [1:0]  hit;
    logic [2:0]  fin_st;
    logic [31:0] fin_drop;
    words_now = 0;
    sent_bytes++;
    case (pos)
      S_MAGIC: begin
        hit        = {b == MAGIC_OLD[field_idx], b == MAGIC_NEW[field_idx]};
        magic_live = magic_live & hit;
        if (magic_live == 2'b00) halt_with(ST_BAD_HEADER);
        else if (field_idx == 2'd3) go_to(S_VERSION);
        else field_idx = field_idx + 2'd1;
      end
      S_VERSION: begin
        if (absorb(b)) begin
          if (field_acc < 1 || field_acc > MAX_VERSION) begin
            halt_with(ST_BAD_VER);
          end else begin
            fmt_ver = field_acc[2:0];
            go_to(S_REC_TYPE);
          end
        end
      end
      S_REC_TYPE: begin
        case (b)
          RTYPE_END:   halt_with(ST_END_MARKER);
          RTYPE_TEXT:  go_to(S_TXT_FLAGS);
          RTYPE_IMAGE: go_to(fmt_ver >= VER_IMG_WIDTH ? S_IMG_WIDTH : S_IMG_LEN);
          RTYPE_TABLE: go_to(fmt_ver >= VER_TBL_FLAGS ? S_TBL_FLAGS : S_TBL_ROWS);
          RTYPE_CHECK: go_to(S_CHECKBOX);
          default:     halt_with(ST_UNKNOWN);
        endcase
      end
      S_TXT_FLAGS: if (absorb(b)) go_to(S_TXT_LEN);
      S_TXT_LEN: begin
        if (absorb(b)) begin
          body_left = field_acc;
          body_sent = '0;
          go_to(body_left == 0 ? S_REC_TYPE : S_TXT_BODY);
        end
      end
      S_TXT_BODY: begin
        emit(b, 1'b0, ST_END_MARKER, '0);
        body_sent = body_sent + 1;
        body_left = body_left - 1;
        if (body_left == 0) begin
          body_sent = '0;
          go_to(S_REC_TYPE);
        end
      end
      S_IMG_WIDTH: if (absorb(b)) go_to(S_IMG_LEN);
      S_IMG_LEN: begin
        if (absorb(b)) begin
          body_left = field_acc;
          go_to(body_left == 0 ? S_REC_TYPE : S_IMG_BODY);
        end
      end
      S_IMG_BODY: begin
        body_left = body_left - 1;
        if (body_left == 0) go_to(S_REC_TYPE);
      end
      S_TBL_FLAGS: if (absorb(b)) go_to(S_TBL_ROWS);
      S_TBL_ROWS: begin
        // an out-of-range row count is held as zero until cols are in
        if (absorb(b)) begin
          tbl_rows = (field_acc >= 1 && field_acc <= MAX_DIM) ? field_acc[10:0] : '0;
          go_to(S_TBL_COLS);
        end
      end
      S_TBL_COLS: begin
        if (absorb(b)) begin
          if (tbl_rows == 0 || field_acc == 0 || field_acc > MAX_DIM) begin
            halt_with(ST_BAD_TABLE);
          end else begin
            tbl_cols   = field_acc[10:0];
            cells_todo = 21'(tbl_rows) * 21'(tbl_cols);
            go_to(S_CELL_LEN);
          end
        end
      end
      S_CELL_LEN: begin
        if (absorb(b)) begin
          body_left = field_acc;
          body_sent = '0;
          if (body_left == 0) begin
            emit(CHAR_SPACE, 1'b0, ST_END_MARKER, '0);
            close_cell();
          end else begin
            go_to(S_CELL_BODY);
          end
        end
      end
      S_CELL_BODY: begin
        emit(b, 1'b0, ST_END_MARKER, '0);
        body_sent = body_sent + 1;
        body_left = body_left - 1;
        if (body_left == 0) begin
          emit(CHAR_SPACE, 1'b0, ST_END_MARKER, '0);
          close_cell();
        end
      end
      S_CHECKBOX: go_to(S_REC_TYPE);
      default: ;
    endcase

    if (last) begin
      fin_drop = '0;
      if (pos == S_HALTED) begin
        fin_st = halt_code;
      end else if (pos == S_MAGIC || pos == S_VERSION) begin
        fin_st = ST_BAD_HEADER;
      end else if (pos == S_REC_TYPE) begin
        fin_st = ST_NO_MARKER;
      end else begin
        fin_st   = ST_TRUNCATED;
        fin_drop = body_sent;
      end
      emit(8'h00, 1'b1, fin_st, fin_drop);
      clear_parser();
    end

    // flag the closing word of this byte's run
    if (words_now > 0) begin
      r = pending_words.pop_back();
      r.last_of_run = 1'b1;
      pending_words.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: one word per call, driven on the falling edge
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic last,
                           input logic typed, input logic [2:0] st);
    res_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid  <= 1'b0;
      blob_byte <= 8'($urandom);
      blob_last <= 1'($urandom);
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    blob_byte <= b;
    blob_last <= last;
    do @(posedge clk); while (in_stall);
    extract_step(b, last);
    // a typed-in status overrides the model's final word
    if (typed) begin
      r = pending_words.pop_back();
      r.status     = st;
      r.drop_count = '0;
      pending_words.push_back(r);
    end
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random blob builder
  // --------------------------------------------------------------------------
  task automatic put_u32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) blob_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_payload(input int len);
    repeat (len) blob_bytes.push_back(8'($urandom));
  endtask

  task automatic build_blob();
    int unsigned sel;
    int unsigned ver;
    int unsigned nrec;
    int unsigned cut;
    logic        legacy;
    logic        huge;
    logic [31:0] bad_v;
    logic [31:0] other_v;
    blob_bytes.delete();
    huge = 1'b0;

    // pure noise now and then
    if ($urandom_range(0, 99) < 5) begin
      put_payload($urandom_range(1, 6));
      return;
    end

    legacy = 1'($urandom);
    for (int i = 0; i < 4; i++) blob_bytes.push_back(legacy ? MAGIC_OLD[i] : MAGIC_NEW[i]);
    if ($urandom_range(0, 99) < 4) blob_bytes[$urandom_range(0, 3)] = 8'($urandom);

    if ($urandom_range(0, 99) < 5) begin
      case ($urandom_range(0, 2))
        0:       ver = 0;
        1:       ver = MAX_VERSION + 1;
        default: ver = $urandom;
      endcase
    end else begin
      ver = $urandom_range(1, MAX_VERSION);
    end
    put_u32(ver);

    nrec = $urandom_range(1, 4);
    for (int k = 0; k < nrec; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        blob_bytes.push_back(RTYPE_TEXT);
        put_u32($urandom);
        sel = $urandom_range(0, 6);
        put_u32(sel);
        put_payload(sel);
      end else if (sel < 55) begin
        blob_bytes.push_back(RTYPE_IMAGE);
        if (ver >= VER_IMG_WIDTH) put_u32($urandom);
        sel = $urandom_range(0, 4);
        put_u32(sel);
        put_payload(sel);
      end else if (sel < 80) begin
        blob_bytes.push_back(RTYPE_TABLE);
        if (ver >= VER_TBL_FLAGS) put_u32($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          // at least one dimension out of range
          case ($urandom_range(0, 2))
            0:       bad_v = 0;
            1:       bad_v = MAX_DIM + 1;
            default: bad_v = $urandom | 32'h0000_0800;
          endcase
          case ($urandom_range(0, 3))
            0:       other_v = 1;
            1:       other_v = MAX_DIM;
            2:       other_v = 0;
            default: other_v = $urandom;
          endcase
          if ($urandom_range(0, 1)) begin
            put_u32(bad_v);
            put_u32(other_v);
          end else begin
            put_u32(other_v);
            put_u32(bad_v);
          end
        end else if (sel < 12) begin
          // largest table, cut short inside its third cell
          put_u32(MAX_DIM);
          put_u32(MAX_DIM);
          put_u32(1);
          put_payload(1);
          put_u32(0);
          put_u32(5);
          put_payload(2);
          huge = 1'b1;
          break;
        end else begin
          sel = $urandom_range(1, 2);
          put_u32(sel);
          other_v = $urandom_range(1, 2);
          put_u32(other_v);
          repeat (sel * other_v) begin
            cut = $urandom_range(0, 3);
            put_u32(cut);
            put_payload(cut);
          end
        end
      end else if (sel < 95) begin
        blob_bytes.push_back(RTYPE_CHECK);
        blob_bytes.push_back(8'($urandom));
      end else begin
        blob_bytes.push_back(8'($urandom_range(RTYPE_CHECK + 1, 255)));
      end
    end

    if (!huge) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        blob_bytes.push_back(RTYPE_END);
        put_payload($urandom_range(0, 3));   // ignored tail
      end else if (sel >= 85) begin
        cut = $urandom_range(1, blob_bytes.size() - 1);
        while (blob_bytes.size() > cut) void'(blob_bytes.pop_back());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted word against the oldest expectation
  // --------------------------------------------------------------------------
  task check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  res_t head_word;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: text_byte %0d is_final %0d status %0d",
               text_byte, is_final, status);
        error_count++;
      end else begin
        head_word = pending_words.pop_front();
        check_field("text_byte",   head_word.text_byte,   text_byte);
        check_field("is_final",    head_word.is_final,    is_final);
        check_field("status",      head_word.status,      status);
        check_field("drop_count",  head_word.drop_count,  drop_count);
        check_field("last_of_run", head_word.last_of_run, last_of_run);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random blobs, drain
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int blob_count;
    blob_count = 0;
    clear_parser();

    // Directed rows: extreme bytes, short header with a good magic,
    // legacy magic with version out of range, current magic with an
    // unknown record type at the top of the byte range.
    directed = '{
      '{8'h00, 1'b1, 1'b1, ST_BAD_HEADER},
      '{8'hFF, 1'b1, 1'b1, ST_BAD_HEADER},
      '{8'h42, 1'b1, 1'b1, ST_BAD_HEADER},
      '{8'h4F, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h4E, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h42, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h46, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h06, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h00, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h00, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h00, 1'b1, 1'b1, ST_BAD_VER},
      '{8'h42, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h4E, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h42, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h46, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h01, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h00, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h00, 1'b0, 1'b0, ST_END_MARKER},
      '{8'h00, 1'b0, 1'b0, ST_END_MARKER},
      '{8'hFF, 1'b1, 1'b1, ST_UNKNOWN}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_word(directed[i].b, directed[i].last, directed[i].typed, directed[i].st);

    // Random blobs; the hold-off lands early, a quiet stretch mid-run
    sent_bytes = 0;
    while (sent_bytes < ITEM_TARGET) begin
      if (blob_count == 2) hold_req = 1'b1;
      calm = (sent_bytes >= 100 && sent_bytes < 160);
      build_blob();
      foreach (blob_bytes[i])
        send_word(blob_bytes[i], i == blob_bytes.size() - 1, 1'b0, ST_END_MARKER);
      blob_count++;
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
